// ===== src/assert_macros.svh =====
// assertion macros used by the cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication checked on every rising clock edge outside reset
`define GSFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked on every rising clock edge outside reset
`define GSFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gsfc_pkg.sv =====
// shared types and constants of the glyph slot cache
package gsfc_pkg;

   // default geometry
   localparam int unsigned SLOT_COUNT_DEF   = 128;
   localparam int unsigned TILE_COLUMNS_DEF = 16;

   // payload field widths
   localparam int unsigned KEY_W  = 64;
   localparam int unsigned SLOT_W = 7;
   localparam int unsigned COL_W  = 4;
   localparam int unsigned ROW_W  = 3;

   // request operations
   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_FLUSH  = 1'b1
   } opcode_type;

endpackage

// ===== src/gsfc_if.sv =====
// valid/ready channel interfaces for requests and responses
interface gsfc_req_if;
   logic                       valid;
   logic                       ready;
   gsfc_pkg::opcode_type       opcode;
   logic [gsfc_pkg::KEY_W-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink (input valid, input opcode, input key, output ready);
endinterface

interface gsfc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [gsfc_pkg::SLOT_W-1:0] slot;
   logic [gsfc_pkg::COL_W-1:0]  tile_column;
   logic [gsfc_pkg::ROW_W-1:0]  tile_row;

   modport source (output valid, output hit, output slot, output tile_column,
                   output tile_row, input ready);
   modport sink (input valid, input hit, input slot, input tile_column,
                 input tile_row, output ready);
endinterface

// ===== src/gsfc_key_ram.sv =====
// key store: one write port, one registered read port
module gsfc_key_ram #(
   parameter int unsigned DEPTH = gsfc_pkg::SLOT_COUNT_DEF,
   parameter int unsigned WIDTH = gsfc_pkg::KEY_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/glyph_slot_fifo_cache.sv =====
// Glyph atlas slot cache, fully associative with round-robin replacement.
// A lookup walks the key RAM one slot per cycle through its single registered
// read port and one 64-bit comparator, stopping at the first valid match. A
// lookup passes from its request beat through the read and compare stages to
// the done state; a miss also writes the key under the replacement pointer. A
// flush goes from its beat straight to the done state. The done state loads
// the response into the output register once that register is free, and the
// next request is taken in the cycle after the response is loaded. Valid
// slots are tracked as the range below the pointer plus a wrapped flag, so no
// clearing pass follows reset or flush. One request is in work at a time; a
// finished response waits in an output register while the next request is
// taken.
`include "assert_macros.svh"

module glyph_slot_fifo_cache #(
   parameter int unsigned SLOT_COUNT   = gsfc_pkg::SLOT_COUNT_DEF,
   parameter int unsigned TILE_COLUMNS = gsfc_pkg::TILE_COLUMNS_DEF
) (
   input logic        clock,
   input logic        reset,
   gsfc_req_if.sink   req_ch,
   gsfc_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
   localparam int unsigned CNT_W   = IDX_W + 1;
   localparam int unsigned TCOL_W  = (TILE_COLUMNS > 16) ? $clog2(TILE_COLUMNS) : 4;
   localparam int unsigned TROW_W  = (IDX_W > 3) ? IDX_W : 3;
   localparam int unsigned XSLOT_W = (IDX_W > 7) ? IDX_W : 7;
   localparam logic [TCOL_W-1:0] COL_LAST = TCOL_W'(TILE_COLUMNS - 1);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SLOT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [gsfc_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic [CNT_W-1:0]           rd_cnt_ff, rd_cnt_in;
   logic [TCOL_W-1:0]          rd_col_ff, rd_col_in;
   logic [TROW_W-1:0]          rd_row_ff, rd_row_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic [TCOL_W-1:0]          cmp_col_ff, cmp_col_in;
   logic [TROW_W-1:0]          cmp_row_ff, cmp_row_in;
   logic [IDX_W-1:0]           next_slot_ff, next_slot_in;
   logic [TCOL_W-1:0]          next_col_ff, next_col_in;
   logic [TROW_W-1:0]          next_row_ff, next_row_in;
   logic                       full_ff, full_in;
   logic                       res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]           res_slot_ff, res_slot_in;
   logic [TCOL_W-1:0]          res_col_ff, res_col_in;
   logic [TROW_W-1:0]          res_row_ff, res_row_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [gsfc_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [gsfc_pkg::COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [gsfc_pkg::ROW_W-1:0] rsp_row_ff, rsp_row_in;

   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [gsfc_pkg::KEY_W-1:0] ram_rd_data;
   logic                       issue;
   logic                       rsp_free;
   logic [XSLOT_W-1:0]         res_slot_x;

   gsfc_key_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (gsfc_pkg::KEY_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (next_slot_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // handshake and response beat
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.slot        = rsp_slot_ff;
   assign rsp_ch.tile_column = rsp_col_ff;
   assign rsp_ch.tile_row    = rsp_row_ff;

   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign issue      = (rd_cnt_ff != limit_ff);
   assign res_slot_x = XSLOT_W'(res_slot_ff);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      limit_in     = limit_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_col_in    = rd_col_ff;
      rd_row_in    = rd_row_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_col_in   = cmp_col_ff;
      cmp_row_in   = cmp_row_ff;
      next_slot_in = next_slot_ff;
      next_col_in  = next_col_ff;
      next_row_in  = next_row_ff;
      full_in      = full_ff;
      res_hit_in   = res_hit_ff;
      res_slot_in  = res_slot_ff;
      res_col_in   = res_col_ff;
      res_row_in   = res_row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      // response beat taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.opcode == gsfc_pkg::OP_FLUSH) begin
                  // flush: drop all valid slots and rewind the pointer
                  next_slot_in = '0;
                  next_col_in  = '0;
                  next_row_in  = '0;
                  full_in      = 1'b0;
                  res_hit_in   = 1'b0;
                  res_slot_in  = '0;
                  res_col_in   = '0;
                  res_row_in   = '0;
                  state_in     = ST_DONE;
               end else begin
                  // lookup: search every slot written since the last flush
                  key_in     = req_ch.key;
                  limit_in   = full_ff ? CNT_FULL : {1'b0, next_slot_ff};
                  rd_cnt_in  = '0;
                  rd_col_in  = '0;
                  rd_row_in  = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // read stage walks the slots with their tile position
            cmp_vld_in = issue;
            cmp_idx_in = rd_cnt_ff[IDX_W-1:0];
            cmp_col_in = rd_col_ff;
            cmp_row_in = rd_row_ff;
            if (issue) begin
               ram_rd_en = 1'b1;
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               if (rd_col_ff == COL_LAST) begin
                  rd_col_in = '0;
                  rd_row_in = rd_row_ff + TROW_W'(1);
               end else begin
                  rd_col_in = rd_col_ff + TCOL_W'(1);
               end
            end
            // compare stage: first match wins, else allocate on exhaustion
            if (cmp_vld_ff && (ram_rd_data == key_ff)) begin
               cmp_vld_in  = 1'b0;
               res_hit_in  = 1'b1;
               res_slot_in = cmp_idx_ff;
               res_col_in  = cmp_col_ff;
               res_row_in  = cmp_row_ff;
               state_in    = ST_DONE;
            end else if (!cmp_vld_ff && !issue) begin
               ram_wr_en   = 1'b1;
               res_hit_in  = 1'b0;
               res_slot_in = next_slot_ff;
               res_col_in  = next_col_ff;
               res_row_in  = next_row_ff;
               state_in    = ST_DONE;
               if (next_slot_ff == IDX_LAST) begin
                  next_slot_in = '0;
                  next_col_in  = '0;
                  next_row_in  = '0;
                  full_in      = 1'b1;
               end else begin
                  next_slot_in = next_slot_ff + IDX_W'(1);
                  if (next_col_ff == COL_LAST) begin
                     next_col_in = '0;
                     next_row_in = next_row_ff + TROW_W'(1);
                  end else begin
                     next_col_in = next_col_ff + TCOL_W'(1);
                  end
               end
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_slot_in  = res_slot_x[gsfc_pkg::SLOT_W-1:0];
               rsp_col_in   = res_col_ff[gsfc_pkg::COL_W-1:0];
               rsp_row_in   = res_row_ff[gsfc_pkg::ROW_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      limit_ff    <= limit_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_col_ff   <= rd_col_in;
      rd_row_ff   <= rd_row_in;
      cmp_idx_ff  <= cmp_idx_in;
      cmp_col_ff  <= cmp_col_in;
      cmp_row_ff  <= cmp_row_in;
      res_hit_ff  <= res_hit_in;
      res_slot_ff <= res_slot_in;
      res_col_ff  <= res_col_in;
      res_row_ff  <= res_row_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         next_slot_ff <= '0;
         next_col_ff  <= '0;
         next_row_ff  <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         next_slot_ff <= next_slot_in;
         next_col_ff  <= next_col_in;
         next_row_ff  <= next_row_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // flush rewinds the pointer and forgets the wrap
   `GSFC_ASSERT_NEXT(a_flush_rewind, clock, reset,
      req_ch.valid && req_ch.ready && req_ch.opcode == gsfc_pkg::OP_FLUSH,
      next_slot_ff == '0 && !full_ff, "flush did not rewind the pointer")
   // compared slots lie inside the valid range
   `GSFC_ASSERT_SAME(a_cmp_in_range, clock, reset, cmp_vld_ff,
      {1'b0, cmp_idx_ff} < limit_ff, "compared slot outside valid range")
   // read counter never passes the search limit
   `GSFC_ASSERT_SAME(a_rd_bound, clock, reset, state_ff == ST_SEARCH,
      rd_cnt_ff <= limit_ff, "read counter passed search limit")
   // pointer tile column stays inside the atlas width
   `GSFC_ASSERT_SAME(a_col_bound, clock, reset, 1'b1,
      next_col_ff <= COL_LAST, "pointer column outside atlas")

endmodule
